FILE: rtl/pss_pkg.sv
// Shared types, constants and the permutation table for the permutation step sequencer.
// Used by pss_div and permutation_step_sequencer_core; depends on nothing else.
package pss_pkg;

    localparam int MOD_BITS   = 6;
    localparam int LEVEL_BITS = 16;
    localparam int CNT_BITS   = $clog2(LEVEL_BITS + 1);
    localparam int PERM_COUNT = 24;

    localparam logic [1:0] CFG_PATTERN_SIZE    = 2'd0;
    localparam logic [1:0] CFG_RESET_ON_OFFSET = 2'd1;
    localparam logic [1:0] CFG_BLANK_TICKS     = 2'd2;

    localparam logic [5:0]  RST_PATTERN_SIZE    = 6'd16;
    localparam logic        RST_RESET_ON_OFFSET = 1'b1;
    localparam logic [15:0] RST_BLANK_TICKS     = 16'd48;

    typedef struct packed {
        logic       clock_edge;
        logic       reset_edge;
        logic [4:0] offset;
        logic [4:0] pattern_select;
        logic       transpose_y;
    } t_in_item;

    typedef struct packed {
        logic        updated;
        logic [4:0]  position;
        logic [15:0] level;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BASE,
        ST_WAIT_BASE,
        ST_WAIT_Y,
        ST_WAIT_LEVEL,
        ST_FINISH
    } t_state;

    // Each row holds the four step values minus one, step 0 in the low two bits.
    localparam logic [7:0] PERM_ROWS [PERM_COUNT] = '{
        {2'd3, 2'd2, 2'd1, 2'd0}, {2'd2, 2'd3, 2'd1, 2'd0},
        {2'd3, 2'd1, 2'd2, 2'd0}, {2'd1, 2'd3, 2'd2, 2'd0},
        {2'd2, 2'd1, 2'd3, 2'd0}, {2'd1, 2'd2, 2'd3, 2'd0},
        {2'd3, 2'd2, 2'd0, 2'd1}, {2'd2, 2'd3, 2'd0, 2'd1},
        {2'd3, 2'd0, 2'd2, 2'd1}, {2'd0, 2'd3, 2'd2, 2'd1},
        {2'd2, 2'd0, 2'd3, 2'd1}, {2'd0, 2'd2, 2'd3, 2'd1},
        {2'd3, 2'd0, 2'd1, 2'd2}, {2'd0, 2'd3, 2'd1, 2'd2},
        {2'd3, 2'd1, 2'd0, 2'd2}, {2'd1, 2'd3, 2'd0, 2'd2},
        {2'd0, 2'd1, 2'd3, 2'd2}, {2'd1, 2'd0, 2'd3, 2'd2},
        {2'd0, 2'd2, 2'd1, 2'd3}, {2'd2, 2'd0, 2'd1, 2'd3},
        {2'd0, 2'd1, 2'd2, 2'd3}, {2'd1, 2'd0, 2'd2, 2'd3},
        {2'd2, 2'd1, 2'd0, 2'd3}, {2'd1, 2'd2, 2'd0, 2'd3}
    };

    function automatic logic [1:0] perm_entry(input logic [4:0] sel, input logic [1:0] step);
        logic [4:0] row_idx;
        logic [7:0] row;
        row_idx = (sel > 5'(PERM_COUNT - 1)) ? 5'(PERM_COUNT - 1) : sel;
        row     = PERM_ROWS[row_idx];
        return row[2*step +: 2];
    endfunction

endpackage

FILE: rtl/pss_div.sv
// Shared restoring divider, one quotient bit per cycle, used for both modulo steps and the level.
// Depends on pss_pkg for the numerator and iteration count widths.
module pss_div #(
    parameter int SW = 6
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [SW-1:0]                   i_divisor,
    input  logic [SW-1:0]                   i_rem_init,
    input  logic [pss_pkg::LEVEL_BITS-1:0]  i_num,
    input  logic [pss_pkg::CNT_BITS-1:0]    i_iters,
    output logic                            o_done,
    output logic [SW-1:0]                   o_rem,
    output logic [pss_pkg::LEVEL_BITS-1:0]  o_quo
);
    import pss_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_BITS-1:0]   r_cnt;
    logic [SW-1:0]         r_rem;
    logic [SW-1:0]         r_div;
    logic [LEVEL_BITS-1:0] r_num;
    logic [LEVEL_BITS-1:0] r_quo;

    logic [SW:0]   w_trial;
    logic [SW:0]   w_diff;
    logic          w_ge;
    logic [SW-1:0] n_rem;

    always_comb begin
        w_trial = {r_rem, r_num[LEVEL_BITS-1]};
        w_diff  = w_trial - {1'b0, r_div};
        w_ge    = w_trial >= {1'b0, r_div};
        n_rem   = w_ge ? w_diff[SW-1:0] : w_trial[SW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_BITS'(1));
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == CNT_BITS'(1))) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_rem_init;
            r_div <= i_divisor;
            r_num <= i_num;
            r_cnt <= i_iters;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_num <= {r_num[LEVEL_BITS-2:0], 1'b0};
            r_quo <= {r_quo[LEVEL_BITS-2:0], w_ge};
            r_cnt <= r_cnt - CNT_BITS'(1);
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
    assign o_quo  = r_quo;

endmodule

FILE: rtl/permutation_step_sequencer_core.sv
// Top level of the permutation step sequencer: handshakes, configuration, step and blanking
// control, and the sequencer that drives the shared divider. Depends on pss_pkg and pss_div.

// One input transfer gives one result transfer. A tick that computes no new value goes from
// ST_IDLE, which accepts it, to ST_FINISH, which loads the result; a tick that computes one
// also runs the shared one-bit-per-cycle divider: a 6-bit modulo, a second 6-bit modulo in Y
// mode, and a 16-bit quotient for the level, each started in turn, then stores the new value
// and loads the result. Input is stalled for the whole of that time, and longer while an
// earlier result still waits in the output register. The result waits in an output register
// until taken.
module permutation_step_sequencer_core #(
    parameter int MAX_SIZE   = 32,
    parameter int BLANK_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  pss_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output pss_pkg::t_out_item o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import pss_pkg::*;

    localparam int SW = $clog2(MAX_SIZE + 1);

    logic [5:0]            r_pattern_size;
    logic                  r_reset_on_offset;
    logic [15:0]           r_blank_ticks;

    t_state                r_state, n_state;
    logic [1:0]            r_step, n_step;
    logic [BLANK_BITS-1:0] r_blank, n_blank;
    logic [4:0]            r_last_off, n_last_off;
    logic [4:0]            r_held_pos, n_held_pos;
    logic [15:0]           r_held_level, n_held_level;
    t_in_item              r_item, n_item;
    logic                  r_adv, n_adv;
    logic [SW-1:0]         r_idx, n_idx;
    logic                  r_out_valid, n_out_valid;
    t_out_item             r_out_data, n_out_data;

    logic [SW-1:0]         w_size;
    logic                  w_reset_hit;
    logic [BLANK_BITS-1:0] w_blank_load;
    logic                  w_gate;
    logic [1:0]            w_step0;
    logic                  w_clk_hit;
    logic [MOD_BITS-1:0]   w_base;
    logic [MOD_BITS-1:0]   w_idx6;
    logic [MOD_BITS-1:0]   w_ymap;

    logic                  div_start;
    logic [SW-1:0]         div_rem_init;
    logic [LEVEL_BITS-1:0] div_num;
    logic [CNT_BITS-1:0]   div_iters;
    logic                  div_done;
    logic [SW-1:0]         div_rem;
    logic [LEVEL_BITS-1:0] div_quo;

    pss_div #(
        .SW(SW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_divisor  (w_size),
        .i_rem_init (div_rem_init),
        .i_num      (div_num),
        .i_iters    (div_iters),
        .o_done     (div_done),
        .o_rem      (div_rem),
        .o_quo      (div_quo)
    );

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_size    <= RST_PATTERN_SIZE;
            r_reset_on_offset <= RST_RESET_ON_OFFSET;
            r_blank_ticks     <= RST_BLANK_TICKS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PATTERN_SIZE:    r_pattern_size    <= i_cfg_data[5:0];
                CFG_RESET_ON_OFFSET: r_reset_on_offset <= i_cfg_data[0];
                CFG_BLANK_TICKS:     r_blank_ticks     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_pattern_size < 6'd2) begin
            w_size = SW'(2);
        end else if (32'(r_pattern_size) > MAX_SIZE) begin
            w_size = SW'(MAX_SIZE);
        end else begin
            w_size = SW'(r_pattern_size);
        end
    end

    always_comb begin
        w_reset_hit  = i_in_data.reset_edge
                       || (r_reset_on_offset && (i_in_data.offset != r_last_off));
        w_blank_load = w_reset_hit ? BLANK_BITS'(r_blank_ticks) : r_blank;
        w_gate       = w_blank_load != '0;
        w_step0      = w_reset_hit ? 2'd0 : r_step;
        w_clk_hit    = i_in_data.clock_edge && !w_gate;
        w_base       = MOD_BITS'(perm_entry(r_item.pattern_select, r_step))
                       + MOD_BITS'(r_item.offset);
        w_idx6       = MOD_BITS'(div_rem);
        w_ymap       = MOD_BITS'({w_idx6[1:0], 2'b00}) + MOD_BITS'(w_idx6[MOD_BITS-1:2]);
    end

    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        n_blank      = r_blank;
        n_last_off   = r_last_off;
        n_held_pos   = r_held_pos;
        n_held_level = r_held_level;
        n_item       = r_item;
        n_adv        = r_adv;
        n_idx        = r_idx;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_data   = r_out_data;
        div_start    = 1'b0;
        div_rem_init = '0;
        div_num      = '0;
        div_iters    = '0;
        o_in_stall   = r_state != ST_IDLE;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_item     = i_in_data;
                    n_last_off = i_in_data.offset;
                    n_blank    = w_gate ? w_blank_load - BLANK_BITS'(1) : w_blank_load;
                    n_step     = w_clk_hit ? w_step0 + 2'd1 : w_step0;
                    n_adv      = w_reset_hit || w_clk_hit;
                    n_state    = (w_reset_hit || w_clk_hit) ? ST_BASE : ST_FINISH;
                end
            end
            ST_BASE: begin
                div_start = 1'b1;
                div_num   = {w_base, {(LEVEL_BITS - MOD_BITS){1'b0}}};
                div_iters = CNT_BITS'(MOD_BITS);
                n_state   = ST_WAIT_BASE;
            end
            ST_WAIT_BASE: begin
                if (div_done) begin
                    div_start = 1'b1;
                    if (r_item.transpose_y) begin
                        div_num   = {w_ymap, {(LEVEL_BITS - MOD_BITS){1'b0}}};
                        div_iters = CNT_BITS'(MOD_BITS);
                        n_state   = ST_WAIT_Y;
                    end else begin
                        div_rem_init = div_rem;
                        div_iters    = CNT_BITS'(LEVEL_BITS);
                        n_idx        = div_rem;
                        n_state      = ST_WAIT_LEVEL;
                    end
                end
            end
            ST_WAIT_Y: begin
                if (div_done) begin
                    div_start    = 1'b1;
                    div_rem_init = div_rem;
                    div_iters    = CNT_BITS'(LEVEL_BITS);
                    n_idx        = div_rem;
                    n_state      = ST_WAIT_LEVEL;
                end
            end
            ST_WAIT_LEVEL: begin
                if (div_done) begin
                    n_held_pos   = 5'(r_idx);
                    n_held_level = div_quo;
                    n_state      = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid         = 1'b1;
                    n_out_data.updated  = r_adv;
                    n_out_data.position = r_held_pos;
                    n_out_data.level    = r_held_level;
                    n_state             = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_step       <= '0;
            r_blank      <= '0;
            r_last_off   <= '0;
            r_held_pos   <= '0;
            r_held_level <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_step       <= n_step;
            r_blank      <= n_blank;
            r_last_off   <= n_last_off;
            r_held_pos   <= n_held_pos;
            r_held_level <= n_held_level;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_adv      <= n_adv;
        r_idx      <= n_idx;
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
